// ----- rtl/simple_glyph_outline_decoder_core_defines.svh -----
// Assertion macros used by the decoder core.
`ifndef SIMPLE_GLYPH_OUTLINE_DECODER_CORE_DEFINES_SVH
`define SIMPLE_GLYPH_OUTLINE_DECODER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SGOD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SGOD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/sgod_pkg.sv -----
package sgod_pkg;

  localparam int DEFAULT_MAX_POINTS = 1024;

  typedef enum logic [3:0] {
    PH_HDR,
    PH_ENDS,
    PH_ILEN,
    PH_SKIP,
    PH_FLAG,
    PH_RPTB,
    PH_FILL,
    PH_X,
    PH_Y,
    PH_DONE,
    PH_ERR
  } phase_t;

  typedef enum logic [1:0] {
    DUE_TICK,
    DUE_BYTE,
    DUE_NONE
  } due_t;

  localparam logic [1:0] FUNC_BYTE    = 2'd0;
  localparam logic [1:0] FUNC_TICK    = 2'd1;
  localparam logic [1:0] FUNC_RESTART = 2'd2;
  localparam logic [1:0] FUNC_BAD     = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_COMPOUND = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_TOO_MANY = 3'd3;
  localparam logic [2:0] ST_RESERVED = 3'd4;
  localparam logic [2:0] ST_OVERRUN  = 3'd5;
  localparam logic [2:0] ST_BAD_ITEM = 3'd6;
  localparam logic [2:0] ST_BBOX     = 3'd7;

endpackage

// ----- rtl/sgod_item_if.sv -----
interface sgod_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] data_byte;

  modport source (output valid, output func, output data_byte, input ready);
  modport sink (input valid, input func, input data_byte, output ready);
endinterface

// ----- rtl/sgod_result_if.sv -----
interface sgod_result_if;
  logic               valid;
  logic               ready;
  logic               vertex_valid;
  logic signed [15:0] coord_x;
  logic signed [15:0] coord_y;
  logic               point_on;
  logic [9:0]         point_index;
  logic               last_point;
  logic               wants_byte;
  logic [2:0]         status;

  modport source (output valid, output vertex_valid, output coord_x, output coord_y,
                  output point_on, output point_index, output last_point,
                  output wants_byte, output status, input ready);
  modport sink (input valid, input vertex_valid, input coord_x, input coord_y,
                input point_on, input point_index, input last_point,
                input wants_byte, input status, output ready);
endinterface

// ----- rtl/simple_glyph_outline_decoder_core.sv -----
// Simple-glyph outline decoder.
// The item channel carries one request per cycle while ready is high: func selects
// a record byte in data_byte, a tick that stands for a point needing no byte, or a
// restart that begins a new glyph. Every request produces exactly one result on the
// result channel; a result with vertex_valid set carries one decoded vertex
// with absolute coordinates, and every result reports wants_byte and status.
// A result passes through the s1 stage register and then the output register, and
// one request can be accepted every cycle while ready is high. The flag and x stores
// are single-port-write memories whose registered read is addressed with the next
// point index, so the flag of the current point is always ready when the next request
// comes. When the receiver stalls, one result waits in the output register and one
// more in the stage in front of it; after that the item channel drops ready
// until the output register drains. Reset clears all decoder state, empties
// both stages and leaves the decoder waiting for the first header byte. The
// stores keep their contents and are rewritten before being read in a glyph.
module simple_glyph_outline_decoder_core #(
  parameter int MAX_POINTS = sgod_pkg::DEFAULT_MAX_POINTS
) (
  input  logic clk,
  input  logic rst,
  sgod_item_if.sink     item,
  sgod_result_if.source result
);
  import sgod_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int PW = $clog2(MAX_POINTS + 1);
  localparam int CW = PW + 9;
  localparam logic [16:0] MAX_LIMIT = 17'(MAX_POINTS);

  phase_t          phase, phase_next;
  logic [15:0]     field_count, field_count_next;
  logic [7:0]      high_byte_hold, high_byte_hold_next;
  logic [14:0]     contour_total, contour_total_next;
  logic [15:0]     bbox_min_hold, bbox_min_hold_next;
  logic [PW-1:0]   point_total, point_total_next;
  logic [15:0]     skip_remaining, skip_remaining_next;
  logic [5:0]      current_flag, current_flag_next;
  logic [7:0]      repeat_remaining, repeat_remaining_next;
  logic [PW-1:0]   point_counter, point_counter_next;
  logic [15:0]     running_x, running_x_next;
  logic [15:0]     running_y, running_y_next;
  logic [2:0]      error_code, error_code_next;

  logic            flag_we, x_we;
  logic [5:0]      flag_wdata, flag_rdata, flag_fwd, flag_cur;
  logic [15:0]     x_wdata, x_rdata, x_fwd, x_cur;
  logic            flag_hit, x_hit;
  logic [AW-1:0]   waddr, raddr;

  logic            accept, advance;
  due_t            due;
  logic [PW-1:0]   pc_inc;
  logic            pc_wrap;
  logic [15:0]     word;

  logic            vtx, vtx_on, vtx_last;
  logic [15:0]     vtx_x, vtx_y;
  logic [9:0]      vtx_idx;

  logic            s1_valid, s1_vertex, s1_on, s1_last;
  logic [15:0]     s1_x, s1_y;
  logic [9:0]      s1_idx;

  assign waddr = point_counter[AW-1:0];
  assign raddr = point_counter_next[AW-1:0];

  sgod_ram #(.W(6), .D(MAX_POINTS)) u_flag_ram (
    .clk(clk), .we(flag_we), .waddr(waddr), .wdata(flag_wdata),
    .raddr(raddr), .rdata(flag_rdata)
  );

  sgod_ram #(.W(16), .D(MAX_POINTS)) u_x_ram (
    .clk(clk), .we(x_we), .waddr(waddr), .wdata(x_wdata),
    .raddr(raddr), .rdata(x_rdata)
  );

  always_ff @(posedge clk) begin
    flag_hit <= flag_we && (waddr == raddr);
    x_hit    <= x_we && (waddr == raddr);
    flag_fwd <= flag_wdata;
    x_fwd    <= x_wdata;
  end

  assign flag_cur = flag_hit ? flag_fwd : flag_rdata;
  assign x_cur    = x_hit ? x_fwd : x_rdata;

  always_comb begin
    case (phase)
      PH_FILL: due = DUE_TICK;
      PH_X: begin
        if (field_count != 16'd0 || flag_cur[1] || !flag_cur[4]) due = DUE_BYTE;
        else due = DUE_TICK;
      end
      PH_Y: begin
        if (field_count != 16'd0 || flag_cur[2] || !flag_cur[5]) due = DUE_BYTE;
        else due = DUE_TICK;
      end
      PH_DONE, PH_ERR: due = DUE_NONE;
      default: due = DUE_BYTE;
    endcase
  end

  assign advance    = s1_valid && (!result.valid || result.ready);
  assign item.ready = !s1_valid || !result.valid || result.ready;
  assign accept     = item.valid && item.ready;
  assign pc_inc     = point_counter + PW'(1);
  assign pc_wrap    = pc_inc >= point_total;
  assign word       = {high_byte_hold, item.data_byte};

  always_comb begin
    logic [15:0] delta;
    logic [7:0]  rep_dec;
    phase_next            = phase;
    field_count_next      = field_count;
    high_byte_hold_next   = high_byte_hold;
    contour_total_next    = contour_total;
    bbox_min_hold_next    = bbox_min_hold;
    point_total_next      = point_total;
    skip_remaining_next   = skip_remaining;
    current_flag_next     = current_flag;
    repeat_remaining_next = repeat_remaining;
    point_counter_next    = point_counter;
    running_x_next        = running_x;
    running_y_next        = running_y;
    error_code_next       = error_code;
    flag_we    = 1'b0;
    flag_wdata = current_flag;
    x_we       = 1'b0;
    x_wdata    = running_x;
    vtx        = 1'b0;
    vtx_x      = 16'd0;
    vtx_y      = 16'd0;
    vtx_on     = 1'b0;
    vtx_idx    = 10'd0;
    vtx_last   = 1'b0;
    delta      = 16'd0;
    rep_dec    = repeat_remaining - 8'd1;

    if (accept) begin
      if (item.func == FUNC_RESTART) begin
        phase_next            = PH_HDR;
        field_count_next      = 16'd0;
        high_byte_hold_next   = 8'd0;
        contour_total_next    = 15'd0;
        bbox_min_hold_next    = 16'd0;
        point_total_next      = '0;
        skip_remaining_next   = 16'd0;
        current_flag_next     = 6'd0;
        repeat_remaining_next = 8'd0;
        point_counter_next    = '0;
        running_x_next        = 16'd0;
        running_y_next        = 16'd0;
        error_code_next       = ST_OK;
      end else if (phase != PH_ERR) begin
        if (item.func == FUNC_BAD || due == DUE_NONE ||
            (item.func == FUNC_BYTE && due != DUE_BYTE) ||
            (item.func == FUNC_TICK && due != DUE_TICK)) begin
          error_code_next = ST_BAD_ITEM;
          phase_next      = PH_ERR;
        end else if (item.func == FUNC_BYTE) begin
          case (phase)
            PH_HDR: begin
              field_count_next = field_count + 16'd1;
              if (!field_count[0]) begin
                high_byte_hold_next = item.data_byte;
              end else if (field_count == 16'd1) begin
                if (word[15]) begin
                  error_code_next = ST_COMPOUND;
                  phase_next      = PH_ERR;
                end else if (word == 16'd0) begin
                  error_code_next = ST_EMPTY;
                  phase_next      = PH_ERR;
                end else begin
                  contour_total_next = word[14:0];
                end
              end else if (field_count == 16'd3) begin
                bbox_min_hold_next = word;
              end else if (field_count == 16'd5) begin
                skip_remaining_next = word;
              end else if (field_count == 16'd7) begin
                if ($signed(word) < $signed(bbox_min_hold)) begin
                  error_code_next = ST_BBOX;
                  phase_next      = PH_ERR;
                end
              end else begin
                if ($signed(word) < $signed(skip_remaining)) begin
                  error_code_next = ST_BBOX;
                  phase_next      = PH_ERR;
                end else begin
                  skip_remaining_next = 16'd0;
                  phase_next          = PH_ENDS;
                  field_count_next    = 16'd0;
                end
              end
            end
            PH_ENDS: begin
              field_count_next = field_count + 16'd1;
              if (!field_count[0]) begin
                high_byte_hold_next = item.data_byte;
              end else if ({1'b0, field_count} + 17'd1 >= {1'b0, contour_total, 1'b0}) begin
                field_count_next = 16'd0;
                if ({1'b0, word} >= MAX_LIMIT) begin
                  error_code_next = ST_TOO_MANY;
                  phase_next      = PH_ERR;
                end else begin
                  point_total_next = PW'({1'b0, word} + 17'd1);
                  phase_next       = PH_ILEN;
                end
              end
            end
            PH_ILEN: begin
              if (field_count == 16'd0) begin
                high_byte_hold_next = item.data_byte;
                field_count_next    = 16'd1;
              end else begin
                field_count_next    = 16'd0;
                skip_remaining_next = word;
                point_counter_next  = '0;
                phase_next          = (word != 16'd0) ? PH_SKIP : PH_FLAG;
              end
            end
            PH_SKIP: begin
              skip_remaining_next = skip_remaining - 16'd1;
              if (skip_remaining == 16'd1) phase_next = PH_FLAG;
            end
            PH_FLAG: begin
              if (item.data_byte[7:6] != 2'b00) begin
                error_code_next = ST_RESERVED;
                phase_next      = PH_ERR;
              end else begin
                current_flag_next = item.data_byte[5:0];
                if (item.data_byte[3]) begin
                  phase_next = PH_RPTB;
                end else begin
                  flag_we    = 1'b1;
                  flag_wdata = item.data_byte[5:0];
                  point_counter_next = pc_inc;
                  if (pc_wrap) begin
                    phase_next         = PH_X;
                    point_counter_next = '0;
                    field_count_next   = 16'd0;
                  end
                end
              end
            end
            PH_RPTB: begin
              if (CW'(point_counter) + CW'(item.data_byte) + CW'(1) > CW'(point_total)) begin
                error_code_next = ST_OVERRUN;
                phase_next      = PH_ERR;
              end else begin
                repeat_remaining_next = item.data_byte;
                flag_we            = 1'b1;
                point_counter_next = pc_inc;
                if (pc_wrap) begin
                  phase_next         = PH_X;
                  point_counter_next = '0;
                  field_count_next   = 16'd0;
                end else begin
                  phase_next = (item.data_byte != 8'd0) ? PH_FILL : PH_FLAG;
                end
              end
            end
            PH_X: begin
              if (!flag_cur[1] && field_count == 16'd0) begin
                high_byte_hold_next = item.data_byte;
                field_count_next    = 16'd1;
              end else begin
                if (flag_cur[1]) begin
                  delta = flag_cur[4] ? {8'd0, item.data_byte}
                                      : 16'd0 - {8'd0, item.data_byte};
                end else begin
                  delta = word;
                end
                running_x_next     = running_x + delta;
                x_we               = 1'b1;
                x_wdata            = running_x + delta;
                field_count_next   = 16'd0;
                point_counter_next = pc_inc;
                if (pc_wrap) begin
                  phase_next         = PH_Y;
                  point_counter_next = '0;
                  running_y_next     = 16'd0;
                end
              end
            end
            PH_Y: begin
              if (!flag_cur[2] && field_count == 16'd0) begin
                high_byte_hold_next = item.data_byte;
                field_count_next    = 16'd1;
              end else begin
                if (flag_cur[2]) begin
                  delta = flag_cur[5] ? {8'd0, item.data_byte}
                                      : 16'd0 - {8'd0, item.data_byte};
                end else begin
                  delta = word;
                end
                running_y_next     = running_y + delta;
                vtx                = 1'b1;
                vtx_x              = x_cur;
                vtx_y              = running_y + delta;
                vtx_on             = flag_cur[0];
                vtx_idx            = 10'(point_counter);
                vtx_last           = pc_wrap;
                field_count_next   = 16'd0;
                point_counter_next = pc_inc;
                if (pc_wrap) phase_next = PH_DONE;
              end
            end
            default: begin
            end
          endcase
        end else begin
          case (phase)
            PH_FILL: begin
              repeat_remaining_next = rep_dec;
              flag_we            = 1'b1;
              point_counter_next = pc_inc;
              if (pc_wrap) begin
                phase_next         = PH_X;
                point_counter_next = '0;
                field_count_next   = 16'd0;
              end else if (rep_dec == 8'd0) begin
                phase_next = PH_FLAG;
              end
            end
            PH_X: begin
              x_we               = 1'b1;
              x_wdata            = running_x;
              field_count_next   = 16'd0;
              point_counter_next = pc_inc;
              if (pc_wrap) begin
                phase_next         = PH_Y;
                point_counter_next = '0;
                running_y_next     = 16'd0;
              end
            end
            PH_Y: begin
              vtx                = 1'b1;
              vtx_x              = x_cur;
              vtx_y              = running_y;
              vtx_on             = flag_cur[0];
              vtx_idx            = 10'(point_counter);
              vtx_last           = pc_wrap;
              field_count_next   = 16'd0;
              point_counter_next = pc_inc;
              if (pc_wrap) phase_next = PH_DONE;
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HDR;
      field_count      <= 16'd0;
      high_byte_hold   <= 8'd0;
      contour_total    <= 15'd0;
      bbox_min_hold    <= 16'd0;
      point_total      <= '0;
      skip_remaining   <= 16'd0;
      current_flag     <= 6'd0;
      repeat_remaining <= 8'd0;
      point_counter    <= '0;
      running_x        <= 16'd0;
      running_y        <= 16'd0;
      error_code       <= ST_OK;
      s1_valid         <= 1'b0;
      result.valid     <= 1'b0;
    end else begin
      phase            <= phase_next;
      field_count      <= field_count_next;
      high_byte_hold   <= high_byte_hold_next;
      contour_total    <= contour_total_next;
      bbox_min_hold    <= bbox_min_hold_next;
      point_total      <= point_total_next;
      skip_remaining   <= skip_remaining_next;
      current_flag     <= current_flag_next;
      repeat_remaining <= repeat_remaining_next;
      point_counter    <= point_counter_next;
      running_x        <= running_x_next;
      running_y        <= running_y_next;
      error_code       <= error_code_next;
      if (accept) s1_valid <= 1'b1;
      else if (advance) s1_valid <= 1'b0;
      if (advance) result.valid <= 1'b1;
      else if (result.ready) result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_vertex <= vtx;
      s1_x      <= vtx_x;
      s1_y      <= vtx_y;
      s1_on     <= vtx_on;
      s1_idx    <= vtx_idx;
      s1_last   <= vtx_last;
    end
    if (advance) begin
      result.vertex_valid <= s1_vertex;
      result.coord_x      <= s1_x;
      result.coord_y      <= s1_y;
      result.point_on     <= s1_on;
      result.point_index  <= s1_idx;
      result.last_point   <= s1_last;
      result.wants_byte   <= (due == DUE_BYTE);
      result.status       <= error_code;
    end
  end

  `include "simple_glyph_outline_decoder_core_defines.svh"

  `SGOD_ASSERT_NOW(a_err_has_code, phase == PH_ERR, error_code != ST_OK, "error phase without code")
  `SGOD_ASSERT_NEXT(a_stage_holds, s1_valid && !advance, s1_valid, "pending result lost")
  `SGOD_ASSERT_NOW(a_vertex_in_y, vtx, accept && phase == PH_Y, "vertex outside y phase")
  `SGOD_ASSERT_NOW(a_pc_in_range, phase == PH_X || phase == PH_Y, point_counter < point_total,
                   "point counter beyond point count")
endmodule

// ----- rtl/sgod_ram.sv -----
module sgod_ram #(
  parameter int W = 8,
  parameter int D = 16,
  localparam int AW = $clog2(D)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
